>>> src/gdn_pkg.sv
// Constants and month-length lookup for the Gregorian day-number converter.
package gdn_pkg;

  // Last valid day count: 31 December 2020
  localparam logic [19:0] MaxCount = 20'd737789;

  // Days in 400, 100, 4 and 1 year spans
  localparam logic [19:0] Days400 = 20'd146097;
  localparam logic [19:0] Days100 = 20'd36524;
  localparam logic [19:0] Days4   = 20'd1461;
  localparam logic [19:0] Days1   = 20'd365;

  // Year span sizes matching the day spans above
  localparam logic [19:0] Yrs400 = 20'd400;
  localparam logic [19:0] Yrs100 = 20'd100;
  localparam logic [19:0] Yrs4   = 20'd4;
  localparam logic [19:0] Yrs1   = 20'd1;

  // Step limits of the century and single-year phases
  localparam logic [4:0] CapQ100 = 5'd3;
  localparam logic [4:0] CapQ1   = 5'd3;
  localparam logic [4:0] CapNone = 5'd31;

  localparam logic [3:0] MonJan = 4'd1;
  localparam logic [3:0] MonFeb = 4'd2;
  localparam logic [3:0] MonDec = 4'd12;

  // Length of month m (1..12), with February stretched in a leap year
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    begin
      case (m)
        4'd2:                      len = leap ? 5'd29 : 5'd28;
        4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
        default:                   len = 5'd31;
      endcase
      return len;
    end
  endfunction

endpackage

>>> src/gregorian_day_number_convert.sv
// Gregorian date / day-count converter built around one shared subtract-and-accumulate step.
// A date needs two passes through the year/month sequence, a shifted count one pass.
// Throughput: one item at a time; set by the span-subtract loop of the shared step unit.
// in_stall_o is low only while the sequencer is idle; a waiting result holds the next item in the finish state.
// Reset: rst_ni (async, active low) clears the sequencer and the output valid.
module gregorian_day_number_convert (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               req_type_i,
  input  logic [4:0]         in_day_i,
  input  logic [3:0]         in_month_i,
  input  logic [10:0]        in_year_i,
  input  logic [19:0]        base_count_i,
  input  logic signed [20:0] offset_days_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [19:0]        out_count_o,
  output logic [4:0]         out_day_o,
  output logic [3:0]         out_month_o,
  output logic [10:0]        out_year_o,
  output logic               range_error_o
);
  import gdn_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_Y400 = 8'b0000_0010,
    ST_Y100 = 8'b0000_0100,
    ST_Y4   = 8'b0000_1000,
    ST_Y1   = 8'b0001_0000,
    ST_MON  = 8'b0010_0000,
    ST_DAY  = 8'b0100_0000,
    ST_FIN  = 8'b1000_0000
  } state_e;

  state_e      state_q, state_d;
  logic        out_valid_q, out_valid_d;

  // Datapath registers: pass 0 turns a date into a count, pass 1 a count into a date
  logic        pass_q, pass_d;
  logic [19:0] rem_q, rem_d;
  logic [19:0] acc_q, acc_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [1:0]  q100_q, q100_d;
  logic [4:0]  q4_q, q4_d;
  logic        leap_q, leap_d;
  logic [3:0]  mon_q, mon_d;
  logic [3:0]  mon_in_q, mon_in_d;
  logic [4:0]  day_in_q, day_in_d;
  logic [19:0] count_q, count_d;
  logic        err_q, err_d;

  // Result register
  logic [19:0] res_count_q, res_count_d;
  logic [4:0]  res_day_q, res_day_d;
  logic [3:0]  res_month_q, res_month_d;
  logic [10:0] res_year_q, res_year_d;
  logic        res_err_q, res_err_d;

  // Shared step unit
  logic [19:0] sub_k, add_k, days_k, yrs_k;
  logic [4:0]  cap_k, len_k;
  logic [20:0] diff;
  logic        ge, take;
  logic [19:0] acc_sum;

  // Input conditioning
  logic [4:0]         day_cl;
  logic [3:0]         mon_cl;
  logic [10:0]        py;
  logic [19:0]        base_sat;
  logic signed [21:0] shift_sum;
  logic               shift_ok;

  // Select the span constants of the current phase
  always_comb begin
    case (state_q)
      ST_Y400: begin days_k = Days400; yrs_k = Yrs400; cap_k = CapNone; end
      ST_Y100: begin days_k = Days100; yrs_k = Yrs100; cap_k = CapQ100; end
      ST_Y4:   begin days_k = Days4;   yrs_k = Yrs4;   cap_k = CapNone; end
      ST_Y1:   begin days_k = Days1;   yrs_k = Yrs1;   cap_k = CapQ1;   end
      default: begin days_k = Days1;   yrs_k = Yrs1;   cap_k = CapNone; end
    endcase
  end

  assign len_k = month_len(mon_q, leap_q);

  // Feed the shared subtract and accumulate
  always_comb begin
    case (state_q)
      ST_MON: begin
        sub_k = {15'd0, len_k};
        add_k = {15'd0, len_k};
      end
      ST_DAY: begin
        sub_k = 20'd0;
        add_k = {15'd0, day_in_q - 5'd1};
      end
      default: begin
        sub_k = pass_q ? days_k : yrs_k;
        add_k = pass_q ? yrs_k : days_k;
      end
    endcase
  end

  assign diff    = {1'b0, rem_q} - {1'b0, sub_k};
  assign ge      = ~diff[20];
  assign take    = ge && (cnt_q != cap_k);
  assign acc_sum = acc_q + add_k;

  // Clamp the date fields and form the shifted count
  assign day_cl    = (in_day_i == 5'd0) ? 5'd1 : in_day_i;
  assign mon_cl    = (in_month_i == 4'd0) ? MonJan :
                     ((in_month_i > MonDec) ? MonDec : in_month_i);
  assign py        = (in_year_i == 11'd0) ? 11'd0 : (in_year_i - 11'd1);
  assign base_sat  = (base_count_i > MaxCount) ? MaxCount : base_count_i;
  assign shift_sum = $signed({2'b00, base_sat}) +
                     $signed({offset_days_i[20], offset_days_i});
  assign shift_ok  = !shift_sum[21] && (shift_sum[20:0] <= {1'b0, MaxCount});

  // Sequence the phases
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    pass_d      = pass_q;
    rem_d       = rem_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    q100_d      = q100_q;
    q4_d        = q4_q;
    leap_d      = leap_q;
    mon_d       = mon_q;
    mon_in_d    = mon_in_q;
    day_in_d    = day_in_q;
    count_d     = count_q;
    err_d       = err_q;
    res_count_d = res_count_q;
    res_day_d   = res_day_q;
    res_month_d = res_month_q;
    res_year_d  = res_year_q;
    res_err_d   = res_err_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          acc_d    = 20'd0;
          cnt_d    = 5'd0;
          day_in_d = day_cl;
          mon_in_d = mon_cl;
          state_d  = ST_Y400;
          if (!req_type_i) begin
            pass_d = 1'b0;
            rem_d  = {9'd0, py};
          end else begin
            pass_d  = 1'b1;
            count_d = shift_ok ? shift_sum[19:0] : base_sat;
            err_d   = !shift_ok;
            rem_d   = shift_ok ? shift_sum[19:0] : base_sat;
          end
        end
      end
      ST_Y400, ST_Y100, ST_Y4, ST_Y1: begin
        if (take) begin
          rem_d = diff[19:0];
          acc_d = acc_sum;
          cnt_d = cnt_q + 5'd1;
        end else begin
          cnt_d = 5'd0;
          case (state_q)
            ST_Y400: state_d = ST_Y100;
            ST_Y100: begin
              q100_d  = cnt_q[1:0];
              state_d = ST_Y4;
            end
            ST_Y4: begin
              q4_d    = cnt_q;
              state_d = ST_Y1;
            end
            default: begin
              // Leap when year is a multiple of 4, but not a non-400 century
              leap_d  = (cnt_q == 5'd3) && !((q4_q == 5'd24) && (q100_q != 2'd3));
              mon_d   = MonJan;
              state_d = ST_MON;
            end
          endcase
        end
      end
      ST_MON: begin
        if (!pass_q) begin
          if (mon_q < mon_in_q) begin
            acc_d = acc_sum;
            mon_d = mon_q + 4'd1;
          end else begin
            state_d = ST_DAY;
          end
        end else begin
          if ((mon_q != MonDec) && ge) begin
            rem_d = diff[19:0];
            mon_d = mon_q + 4'd1;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_DAY: begin
        // Add the day of month, saturate, then decode the count back to a date
        if (acc_sum > MaxCount) begin
          count_d = MaxCount;
          rem_d   = MaxCount;
          err_d   = 1'b1;
        end else begin
          count_d = acc_sum;
          rem_d   = acc_sum;
          err_d   = 1'b0;
        end
        acc_d   = 20'd0;
        cnt_d   = 5'd0;
        pass_d  = 1'b1;
        state_d = ST_Y400;
      end
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          res_count_d = count_q;
          res_day_d   = rem_q[4:0] + 5'd1;
          res_month_d = mon_q;
          res_year_d  = acc_q[10:0] + 11'd1;
          res_err_d   = err_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Advance the datapath and result registers
  always_ff @(posedge clk_i) begin
    pass_q      <= pass_d;
    rem_q       <= rem_d;
    acc_q       <= acc_d;
    cnt_q       <= cnt_d;
    q100_q      <= q100_d;
    q4_q        <= q4_d;
    leap_q      <= leap_d;
    mon_q       <= mon_d;
    mon_in_q    <= mon_in_d;
    day_in_q    <= day_in_d;
    count_q     <= count_d;
    err_q       <= err_d;
    res_count_q <= res_count_d;
    res_day_q   <= res_day_d;
    res_month_q <= res_month_d;
    res_year_q  <= res_year_d;
    res_err_q   <= res_err_d;
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign out_count_o   = res_count_q;
  assign out_day_o     = res_day_q;
  assign out_month_o   = res_month_q;
  assign out_year_o    = res_year_q;
  assign range_error_o = res_err_q;

`ifndef SYNTHESIS
  // A new result appears only when the sequencer finishes an item
  a_rise_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FIN))
    else $error("result valid rose outside the finish state");

  // Delivered results stay within the supported calendar range
  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_count_o <= MaxCount) && (out_month_o >= MonJan) &&
                    (out_month_o <= MonDec) && (out_day_o != 5'd0))
    else $error("result fields out of range");

  // Capped phases never run past three steps
  a_cap_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_Y100 || state_q == ST_Y1) |-> (cnt_q <= 5'd3))
    else $error("capped phase step count exceeded");

  // Month walk stays within the year
  a_month_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MON) |-> (mon_q >= MonJan) && (mon_q <= MonDec))
    else $error("month index left 1..12");
`endif

endmodule
